/* rtl/lmss_pkg.sv */
`default_nettype none

package lmss_pkg;

	localparam int MATRIX_SIZE = 8;
	localparam int FRAME_DEPTH = 64;

	// Command codes carried by the cmd field
	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_WRITE  = 3'd1,
		CMD_PAUSE  = 3'd2,
		CMD_RESUME = 3'd3,
		CMD_FASTER = 3'd4,
		CMD_SLOWER = 3'd5
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SCAN_MODE    = 2'd0,
		REG_DWELL_TICKS  = 2'd1,
		REG_SCROLL_STEPS = 2'd2
	} reg_idx_t;

	localparam logic        RST_SCAN_MODE    = 1'b1;
	localparam logic [15:0] RST_DWELL_TICKS  = 16'd2500;
	localparam logic [5:0]  RST_SCROLL_STEPS = 6'd30;
	localparam logic [7:0]  RST_FRAMES_PER_WINDOW = 8'd10;
	localparam logic [7:0]  FPW_STEP = 8'd2;
	localparam logic [7:0]  FPW_MAX  = 8'd254;

	typedef struct packed {
		logic        scan_mode;
		logic [15:0] dwell_ticks;
		logic [5:0]  scroll_steps;
	} cfg_t;

	// What the display shows after an item has been applied
	typedef struct packed {
		logic [2:0] col;
		logic [5:0] offset;
		logic       paused;
	} view_t;

endpackage

`default_nettype wire

/* rtl/lmss_scan_state.sv */
`default_nettype none

module lmss_scan_state (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  wire  [2:0]          cmd,
	input  lmss_pkg::cfg_t      cfg,
	output lmss_pkg::view_t     view
);

	localparam int          LIM  = lmss_pkg::FRAME_DEPTH - lmss_pkg::MATRIX_SIZE + 1;
	localparam logic [8:0]  LIM9 = 9'(LIM);

	logic [2:0]  col_q, col_d;
	logic [15:0] tick_q, tick_d;
	logic [7:0]  rep_q, rep_d;
	logic [5:0]  pos_q, pos_d;
	logic [7:0]  fpw_q, fpw_d;
	logic        pause_q, pause_d;

	logic [15:0] dwell;
	logic [7:0]  fpw;
	logic [5:0]  limit;
	logic        held_now;
	logic [16:0] tick_inc;
	logic [8:0]  rep_inc;
	logic [6:0]  pos_inc;
	logic [2:0]  col_inc;
	logic [8:0]  fpw_up;

	always_comb begin
		dwell    = (cfg.dwell_ticks == 16'd0) ? 16'd1 : cfg.dwell_ticks;
		fpw      = (fpw_q == 8'd0) ? 8'd1 : fpw_q;
		if (cfg.scroll_steps == 6'd0)
			limit = 6'd1;
		else if ({3'b000, cfg.scroll_steps} > LIM9)
			limit = LIM9[5:0];
		else
			limit = cfg.scroll_steps;
		held_now = cfg.scan_mode && pause_q && (col_q == 3'd0) && (tick_q == 16'd0)
			&& (rep_q == 8'd0);
		tick_inc = {1'b0, tick_q} + 17'd1;
		rep_inc  = {1'b0, rep_q} + 9'd1;
		pos_inc  = {1'b0, pos_q} + 7'd1;
		col_inc  = col_q + 3'd1;
		fpw_up   = {1'b0, fpw_q} + {1'b0, lmss_pkg::FPW_STEP};
	end

	// Next state for one accepted word
	always_comb begin
		col_d   = col_q;
		tick_d  = tick_q;
		rep_d   = rep_q;
		pos_d   = pos_q;
		fpw_d   = fpw_q;
		pause_d = pause_q;
		if (step) begin
			unique case (lmss_pkg::cmd_t'(cmd))
				lmss_pkg::CMD_TICK: begin
					if (!held_now) begin
						if (tick_inc < {1'b0, dwell}) begin
							tick_d = tick_inc[15:0];
						end else begin
							tick_d = 16'd0;
							col_d  = col_inc;
							if (col_inc == 3'd0 && cfg.scan_mode) begin
								if (rep_inc < {1'b0, fpw}) begin
									rep_d = rep_inc[7:0];
								end else begin
									rep_d = 8'd0;
									pos_d = (pos_inc >= {1'b0, limit}) ? 6'd0 : pos_inc[5:0];
								end
							end
						end
					end
				end
				lmss_pkg::CMD_WRITE: begin
				end
				lmss_pkg::CMD_PAUSE:  pause_d = 1'b1;
				lmss_pkg::CMD_RESUME: pause_d = 1'b0;
				lmss_pkg::CMD_FASTER: begin
					fpw_d = (fpw_q >= lmss_pkg::FPW_STEP) ? fpw_q - lmss_pkg::FPW_STEP : 8'd0;
				end
				lmss_pkg::CMD_SLOWER: begin
					fpw_d = (fpw_up > {1'b0, lmss_pkg::FPW_MAX}) ? lmss_pkg::FPW_MAX : fpw_up[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		view.col    = col_d;
		view.offset = cfg.scan_mode ? pos_d : 6'd0;
		view.paused = cfg.scan_mode && pause_d && (col_d == 3'd0) && (tick_d == 16'd0)
			&& (rep_d == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= 3'd0;
			tick_q  <= 16'd0;
			rep_q   <= 8'd0;
			pos_q   <= 6'd0;
			fpw_q   <= lmss_pkg::RST_FRAMES_PER_WINDOW;
			pause_q <= 1'b0;
		end else begin
			col_q   <= col_d;
			tick_q  <= tick_d;
			rep_q   <= rep_d;
			pos_q   <= pos_d;
			fpw_q   <= fpw_d;
			pause_q <= pause_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/led_matrix_scroll_scanner.sv */
// 8x8 LED matrix column scanner with optional window scrolling.
// Input channel (in_valid/in_ready) carries one command word: a tick, a frame
// byte write, pause, resume, speed up or slow down. Every accepted word yields
// exactly one output word (out_valid/out_ready) holding the column drive
// (active low), the row byte of the lit column, the window offset and the
// paused flag, all as they stand after that command took effect.
// Throughput: one word per clock while out_ready stays high. Each word passes
// a registered read of the frame store RAM and then the output register.
// A byte written by a command is visible to the same word's row lookup
// (write-to-read forwarding) and to every later word.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one of scan_mode,
// dwell_ticks and scroll_steps per write; write only while no word is in flight.
// Reset clears the scan counters, sets frames per window to 10 and loads the
// register defaults (scroll mode, 2500 ticks dwell, 30 steps). Frame store
// contents are unknown until written; there is no clearing pass.
// When the receiver stalls, the output word holds and one more word is taken
// into the read stage; after that in_ready drops until the output drains.
`default_nettype none

module led_matrix_scroll_scanner (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_wr_en,
	input  wire  [1:0] cfg_index,
	input  wire  [15:0] cfg_data,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [2:0] cmd,
	input  wire  [5:0] byte_addr,
	input  wire  [7:0] byte_value,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] col_drive,
	output logic [7:0] row_drive,
	output logic [5:0] window_offset,
	output logic       is_paused
);

	localparam int         AW      = $clog2(lmss_pkg::FRAME_DEPTH);
	localparam int         IW      = (AW > 7) ? AW : 7;
	localparam logic [8:0] DEPTH9  = 9'(lmss_pkg::FRAME_DEPTH);

	// configuration registers
	lmss_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_mode    <= lmss_pkg::RST_SCAN_MODE;
			cfg_q.dwell_ticks  <= lmss_pkg::RST_DWELL_TICKS;
			cfg_q.scroll_steps <= lmss_pkg::RST_SCROLL_STEPS;
		end else if (cfg_wr_en) begin
			unique case (lmss_pkg::reg_idx_t'(cfg_index))
				lmss_pkg::REG_SCAN_MODE:    cfg_q.scan_mode    <= cfg_data[0];
				lmss_pkg::REG_DWELL_TICKS:  cfg_q.dwell_ticks  <= cfg_data;
				lmss_pkg::REG_SCROLL_STEPS: cfg_q.scroll_steps <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// handshake and pipeline control
	logic accept;
	logic s1_valid_s1;
	logic s1_move;
	logic out_valid_s2;

	assign s1_move  = s1_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !s1_valid_s1 || s1_move;
	assign accept   = in_valid && in_ready;

	// scan counters update in the acceptance cycle
	lmss_pkg::view_t view;

	lmss_scan_state u_state (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (accept),
		.cmd   (cmd),
		.cfg   (cfg_q),
		.view  (view)
	);

	// frame store addressing: the read index never passes the store's end,
	// the write address wraps modulo the depth
	logic [6:0]    rd_sum;
	logic [IW-1:0] rd_wide;
	logic [AW-1:0] rd_addr;
	logic [8:0]    wr_wide;
	logic [AW-1:0] wr_addr;
	logic          wr_en;
	logic          fwd_hit;

	always_comb begin
		rd_sum  = {1'b0, view.offset} + {4'b0000, view.col};
		rd_wide = IW'(rd_sum);
		rd_addr = rd_wide[AW-1:0];
		wr_wide = {3'b000, byte_addr};
		for (int i = 0; i < 7; i++) begin
			if (wr_wide >= DEPTH9)
				wr_wide = wr_wide - DEPTH9;
		end
		wr_addr = wr_wide[AW-1:0];
		wr_en   = accept && (lmss_pkg::cmd_t'(cmd) == lmss_pkg::CMD_WRITE);
		fwd_hit = wr_en && (wr_addr == rd_addr);
	end

	// frame store: one write port, one registered read port
	logic [7:0] frame_mem [lmss_pkg::FRAME_DEPTH];
	logic [7:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			frame_mem[wr_addr] <= byte_value;
		if (accept)
			rd_data_s1 <= frame_mem[rd_addr];
	end

	// read stage payload
	lmss_pkg::view_t view_s1;
	logic            fwd_hit_s1;
	logic [7:0]      fwd_byte_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			view_s1     <= view;
			fwd_hit_s1  <= fwd_hit;
			fwd_byte_s1 <= byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// output stage: hold while stalled, advance when the read stage moves
	logic [7:0] col_drive_s2;
	logic [7:0] row_drive_s2;
	logic [5:0] offset_s2;
	logic       paused_s2;

	always_ff @(posedge clk) begin
		if (s1_move) begin
			col_drive_s2 <= ~(8'd1 << view_s1.col);
			row_drive_s2 <= fwd_hit_s1 ? fwd_byte_s1 : rd_data_s1;
			offset_s2    <= view_s1.offset;
			paused_s2    <= view_s1.paused;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_move) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	assign out_valid     = out_valid_s2;
	assign col_drive     = col_drive_s2;
	assign row_drive     = row_drive_s2;
	assign window_offset = offset_s2;
	assign is_paused     = paused_s2;

	// exactly one column line is driven low
	a_one_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> ($countones(~col_drive_s2) == 1))
		else $error("column drive does not select exactly one column");

	// a word in the read stage is never dropped while it cannot move
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !s1_move) |=> s1_valid_s1)
		else $error("read stage word lost while stalled");

	// a paused display always shows column 0
	a_pause_col: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && paused_s2) |-> !col_drive_s2[0])
		else $error("paused output not on column 0");

	// static mode shows offset 0
	a_static_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !cfg_q.scan_mode) |-> (offset_s2 == 6'd0))
		else $error("nonzero window offset in static mode");

endmodule

`default_nettype wire
